@@ hw/rtl/ppna_pkg.sv @@
package ppna_pkg;

   localparam int PIXEL_COLUMNS    = 185;
   localparam int PIXEL_ROWS       = 388;
   localparam int SECTOR_COUNT     = 2;
   localparam int PIXEL_DEPTH      = PIXEL_COLUMNS * PIXEL_ROWS * SECTOR_COUNT;
   localparam int INDEX_BITS       = 18;
   localparam int FRAME_COUNT_BITS = 16;
   localparam logic [FRAME_COUNT_BITS-1:0] FRAME_MAX = '1;

   localparam int SUM_BITS = 32;
   localparam int SQ_BITS  = 46;

   // Shared long divider: 62-bit difference shifted by 16, divided by n squared.
   localparam int DIV_DIVIDEND_BITS = 78;
   localparam int DIV_DIVISOR_BITS  = 32;
   localparam int DIV_QUOT_BITS     = 48;

   localparam int SQRT_IN_BITS   = 48;
   localparam int SQRT_OUT_BITS  = 24;
   localparam logic [SQRT_IN_BITS-1:0] SQRT_FIRST_ONE = 48'h4000_0000_0000;

   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_READOUT    = 1'b1;

   typedef struct packed {
      logic                    opcode;
      logic [INDEX_BITS-1:0]   pixel_index;
      logic signed [15:0]      pixel_value;
      logic                    last_of_frame;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]   result_pixel;
      logic signed [23:0]      mean_q8;
      logic [23:0]             stddev_q8;
      logic [15:0]             frames_counted;
      logic                    count_saturated;
   } rsp_type;

   // Classified command as it travels from the front to the back.
   typedef struct packed {
      logic                    is_readout;
      logic                    in_range;
      logic [INDEX_BITS-1:0]   pixel_index;
      logic signed [15:0]      pixel_value;
      logic                    last_of_frame;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } fifo_head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] sum;
      logic [SQ_BITS-1:0]  sum_sq;
   } mem_word_type;

   typedef struct packed {
      logic                         start;
      logic [DIV_DIVIDEND_BITS-1:0] dividend;
      logic [DIV_DIVISOR_BITS-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic [DIV_QUOT_BITS-1:0] quotient;
      logic                     overflow;
   } div_rsp_type;

   typedef struct packed {
      logic                    start;
      logic [SQRT_IN_BITS-1:0] value;
   } sqrt_req_type;

   typedef struct packed {
      logic                     done;
      logic [SQRT_OUT_BITS-1:0] root;
   } sqrt_rsp_type;

endpackage

@@ hw/rtl/ppna_front.sv @@
// Accepts requests, classifies them and holds them in a two-entry queue.
module ppna_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  ppna_pkg::req_type         req_data,
   output ppna_pkg::fifo_head_type   head,
   input  ppna_pkg::back_status_type status
);

   ppna_pkg::cmd_type entry_ff [2];
   ppna_pkg::cmd_type entry_in [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push_ok;
   logic              pop_ok;
   ppna_pkg::cmd_type new_cmd;

   assign req_full   = (count_ff == 2'd2) || status.clearing;
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = status.pop && (count_ff != 2'd0);
   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.is_readout    = (req_data.opcode == ppna_pkg::OP_READOUT);
      new_cmd.in_range      = ({14'd0, req_data.pixel_index} < 32'(ppna_pkg::PIXEL_DEPTH));
      new_cmd.pixel_index   = req_data.pixel_index;
      new_cmd.pixel_value   = req_data.pixel_value;
      new_cmd.last_of_frame = req_data.last_of_frame;

      entry_in = entry_ff;
      if (push_ok) begin
         entry_in[wr_ptr_ff] = new_cmd;
      end
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/ppna_div.sv @@
// Restoring long divider, one quotient bit per cycle.
module ppna_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ppna_pkg::div_req_type div_req,
   output ppna_pkg::div_rsp_type div_rsp
);

   logic [ppna_pkg::DIV_DIVIDEND_BITS-1:0] dend_ff, dend_in;
   logic [ppna_pkg::DIV_DIVISOR_BITS-1:0]  dsor_ff, dsor_in;
   logic [ppna_pkg::DIV_DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [ppna_pkg::DIV_QUOT_BITS-1:0]     quot_ff, quot_in;
   logic                                   ovf_ff, ovf_in;
   logic                                   busy_ff, busy_in;
   logic                                   done_ff, done_in;
   logic [6:0]                             count_ff, count_in;
   logic [ppna_pkg::DIV_DIVISOR_BITS:0]    shifted;
   logic [ppna_pkg::DIV_DIVISOR_BITS:0]    diff;
   logic                                   fits;

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;
   assign div_rsp.overflow = ovf_ff;

   always_comb begin
      shifted  = {rem_ff, dend_ff[ppna_pkg::DIV_DIVIDEND_BITS-1]};
      diff     = shifted - {1'b0, dsor_ff};
      fits     = (shifted >= {1'b0, dsor_ff});
      dend_in  = dend_ff;
      dsor_in  = dsor_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      ovf_in   = ovf_ff;
      busy_in  = busy_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (div_req.start) begin
         dend_in  = div_req.dividend;
         dsor_in  = div_req.divisor;
         rem_in   = '0;
         quot_in  = '0;
         ovf_in   = 1'b0;
         busy_in  = 1'b1;
         count_in = '0;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[ppna_pkg::DIV_DIVISOR_BITS-1:0]
                         : shifted[ppna_pkg::DIV_DIVISOR_BITS-1:0];
         dend_in  = dend_ff << 1;
         quot_in  = {quot_ff[ppna_pkg::DIV_QUOT_BITS-2:0], fits};
         ovf_in   = ovf_ff | quot_ff[ppna_pkg::DIV_QUOT_BITS-1];
         count_in = count_ff + 7'd1;
         if (count_ff == 7'(ppna_pkg::DIV_DIVIDEND_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dend_ff <= dend_in;
      dsor_ff <= dsor_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      ovf_ff  <= ovf_in;
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ hw/rtl/ppna_sqrt.sv @@
// Digit-by-digit integer square root, one result bit per cycle.
module ppna_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  ppna_pkg::sqrt_req_type sqrt_req,
   output ppna_pkg::sqrt_rsp_type sqrt_rsp
);

   logic [ppna_pkg::SQRT_IN_BITS-1:0] val_ff, val_in;
   logic [ppna_pkg::SQRT_IN_BITS-1:0] res_ff, res_in;
   logic [ppna_pkg::SQRT_IN_BITS-1:0] one_ff, one_in;
   logic [4:0]                        count_ff, count_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [ppna_pkg::SQRT_IN_BITS:0]   trial;
   logic                              ge;

   assign sqrt_rsp.done = done_ff;
   assign sqrt_rsp.root = res_ff[ppna_pkg::SQRT_OUT_BITS-1:0];

   always_comb begin
      trial    = {1'b0, res_ff} + {1'b0, one_ff};
      ge       = ({1'b0, val_ff} >= trial);
      val_in   = val_ff;
      res_in   = res_ff;
      one_in   = one_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (sqrt_req.start) begin
         val_in   = sqrt_req.value;
         res_in   = '0;
         one_in   = ppna_pkg::SQRT_FIRST_ONE;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            val_in = val_ff - trial[ppna_pkg::SQRT_IN_BITS-1:0];
            res_in = (res_ff >> 1) + one_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         one_in   = one_ff >> 2;
         count_in = count_ff + 5'd1;
         if (count_ff == 5'(ppna_pkg::SQRT_OUT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      res_ff <= res_in;
      one_ff <= one_in;
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

endmodule

@@ hw/rtl/ppna_back.sv @@
// Executes commands: clears and updates the pixel store, and works out readouts.
module ppna_back (
   input  logic                       clock,
   input  logic                       reset,
   input  ppna_pkg::fifo_head_type    head,
   output ppna_pkg::back_status_type  status,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output ppna_pkg::rsp_type          rsp_data
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_ACC_READ, ST_ACC_WRITE, ST_RD_READ, ST_RD_MAG,
      ST_MUL_ALO, ST_MUL_AHI, ST_MUL_B, ST_MUL_N, ST_ADD_A, ST_SUB_D,
      ST_MEAN_DIV, ST_VAR_DIV, ST_SQRT, ST_RESULT
   } state_type;

   ppna_pkg::mem_word_type pixel_mem_ff [ppna_pkg::PIXEL_DEPTH];
   ppna_pkg::mem_word_type mem_rd_ff;
   ppna_pkg::mem_word_type wr_data;
   logic [ppna_pkg::INDEX_BITS-1:0] wr_addr;
   logic                            wr_en;

   state_type                              state_ff, state_in;
   ppna_pkg::cmd_type                      cmd_ff, cmd_in;
   logic [ppna_pkg::INDEX_BITS-1:0]        clear_addr_ff, clear_addr_in;
   logic [ppna_pkg::FRAME_COUNT_BITS-1:0]  frame_count_ff, frame_count_in;
   logic                                   dropped_ff, dropped_in;
   logic [31:0]                            sample_sq_ff, sample_sq_in;
   logic [31:0]                            mag_ff, mag_in;
   logic                                   neg_ff, neg_in;
   logic [ppna_pkg::SQ_BITS-1:0]           sq_ff, sq_in;
   logic [47:0]                            a_lo_ff, a_lo_in;
   logic [29:0]                            a_hi_ff, a_hi_in;
   logic [63:0]                            b_ff, b_in;
   logic [31:0]                            nsq_ff, nsq_in;
   logic [61:0]                            a_ff, a_in;
   logic [61:0]                            diff_ff, diff_in;
   logic                                   var_ok_ff, var_ok_in;
   logic [23:0]                            mean_ff, mean_in;
   logic [23:0]                            sd_ff, sd_in;
   logic                                   out_valid_ff, out_valid_in;
   ppna_pkg::rsp_type                      out_data_ff, out_data_in;

   ppna_pkg::div_req_type  div_req;
   ppna_pkg::div_rsp_type  div_rsp;
   ppna_pkg::sqrt_req_type sqrt_req;
   ppna_pkg::sqrt_rsp_type sqrt_rsp;

   logic [47:0] q_clamped;
   logic [31:0] sum_rd;

   ppna_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   ppna_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .sqrt_req (sqrt_req),
      .sqrt_rsp (sqrt_rsp)
   );

   assign rsp_empty       = !out_valid_ff;
   assign rsp_data        = out_data_ff;
   assign status.clearing = (state_ff == ST_CLEAR);

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      clear_addr_in  = clear_addr_ff;
      frame_count_in = frame_count_ff;
      dropped_in     = dropped_ff;
      sample_sq_in   = sample_sq_ff;
      mag_in         = mag_ff;
      neg_in         = neg_ff;
      sq_in          = sq_ff;
      a_lo_in        = a_lo_ff;
      a_hi_in        = a_hi_ff;
      b_in           = b_ff;
      nsq_in         = nsq_ff;
      a_in           = a_ff;
      diff_in        = diff_ff;
      var_ok_in      = var_ok_ff;
      mean_in        = mean_ff;
      sd_in          = sd_ff;
      out_valid_in   = out_valid_ff && !rsp_pop;
      out_data_in    = out_data_ff;
      status.pop     = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = cmd_ff.pixel_index;
      wr_data        = '0;
      sum_rd         = mem_rd_ff.sum;
      q_clamped      = '0;
      div_req.start    = 1'b0;
      div_req.dividend = 78'({mag_ff, 9'd0}) + 78'(frame_count_ff);
      div_req.divisor  = 32'({frame_count_ff, 1'b0});
      sqrt_req.start   = 1'b0;
      sqrt_req.value   = div_rsp.quotient;

      case (state_ff)
         ST_CLEAR: begin
            wr_en         = 1'b1;
            wr_addr       = clear_addr_ff;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == ppna_pkg::INDEX_BITS'(ppna_pkg::PIXEL_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               status.pop = 1'b1;
               cmd_in     = head.cmd;
               if (!head.cmd.is_readout) begin
                  if (frame_count_ff == ppna_pkg::FRAME_MAX) begin
                     if (head.cmd.last_of_frame) begin
                        dropped_in = 1'b1;
                     end
                  end else begin
                     if (head.cmd.last_of_frame) begin
                        frame_count_in = frame_count_ff + 1'b1;
                     end
                     if (head.cmd.in_range) begin
                        state_in = ST_ACC_READ;
                     end
                  end
               end else begin
                  mean_in = '0;
                  sd_in   = '0;
                  if (head.cmd.in_range && (frame_count_ff != '0)) begin
                     state_in = ST_RD_READ;
                  end else begin
                     state_in = ST_RESULT;
                  end
               end
            end
         end
         ST_ACC_READ: begin
            sample_sq_in = 32'(cmd_ff.pixel_value * cmd_ff.pixel_value);
            state_in     = ST_ACC_WRITE;
         end
         ST_ACC_WRITE: begin
            wr_en          = 1'b1;
            wr_data.sum    = mem_rd_ff.sum + 32'(cmd_ff.pixel_value);
            wr_data.sum_sq = mem_rd_ff.sum_sq + {14'd0, sample_sq_ff};
            state_in       = ST_IDLE;
         end
         ST_RD_READ: begin
            state_in = ST_RD_MAG;
         end
         ST_RD_MAG: begin
            neg_in   = sum_rd[31];
            mag_in   = sum_rd[31] ? (~sum_rd + 32'd1) : sum_rd;
            sq_in    = mem_rd_ff.sum_sq;
            state_in = ST_MUL_ALO;
         end
         ST_MUL_ALO: begin
            a_lo_in  = 48'(frame_count_ff) * 48'(sq_ff[31:0]);
            state_in = ST_MUL_AHI;
         end
         ST_MUL_AHI: begin
            a_hi_in  = 30'(frame_count_ff) * 30'(sq_ff[ppna_pkg::SQ_BITS-1:32]);
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            b_in     = 64'(mag_ff) * 64'(mag_ff);
            state_in = ST_MUL_N;
         end
         ST_MUL_N: begin
            nsq_in   = 32'(frame_count_ff) * 32'(frame_count_ff);
            state_in = ST_ADD_A;
         end
         ST_ADD_A: begin
            a_in     = 62'(a_lo_ff) + {a_hi_ff, 32'd0};
            state_in = ST_SUB_D;
         end
         ST_SUB_D: begin
            diff_in   = a_ff - b_ff[61:0];
            var_ok_in = (frame_count_ff > 16'd1) && ({2'b00, a_ff} >= b_ff);
            // The rounded mean goes first through the shared divider.
            div_req.start = 1'b1;
            state_in      = ST_MEAN_DIV;
         end
         ST_MEAN_DIV: begin
            div_req.dividend = {diff_ff, 16'd0};
            div_req.divisor  = nsq_ff;
            if (div_rsp.done) begin
               if (neg_ff) begin
                  q_clamped = (div_rsp.quotient > 48'd8388608) ? 48'd8388608
                                                               : div_rsp.quotient;
                  mean_in   = 24'd0 - q_clamped[23:0];
               end else begin
                  q_clamped = (div_rsp.quotient > 48'd8388607) ? 48'd8388607
                                                               : div_rsp.quotient;
                  mean_in   = q_clamped[23:0];
               end
               if (var_ok_ff) begin
                  div_req.start = 1'b1;
                  state_in      = ST_VAR_DIV;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_VAR_DIV: begin
            if (div_rsp.done) begin
               if (div_rsp.overflow) begin
                  sd_in    = 24'hFFFFFF;
                  state_in = ST_RESULT;
               end else begin
                  sqrt_req.start = 1'b1;
                  state_in       = ST_SQRT;
               end
            end
         end
         ST_SQRT: begin
            if (sqrt_rsp.done) begin
               sd_in    = sqrt_rsp.root;
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in                = 1'b1;
               out_data_in.result_pixel    = cmd_ff.pixel_index;
               out_data_in.mean_q8         = mean_ff;
               out_data_in.stddev_q8       = sd_ff;
               out_data_in.frames_counted  = 16'(frame_count_ff);
               out_data_in.count_saturated = dropped_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pixel_mem_ff[wr_addr] <= wr_data;
      end
      mem_rd_ff <= pixel_mem_ff[cmd_ff.pixel_index];
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      sample_sq_ff <= sample_sq_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      sq_ff        <= sq_in;
      a_lo_ff      <= a_lo_in;
      a_hi_ff      <= a_hi_in;
      b_ff         <= b_in;
      nsq_ff       <= nsq_in;
      a_ff         <= a_in;
      diff_ff      <= diff_in;
      var_ok_ff    <= var_ok_in;
      mean_ff      <= mean_in;
      sd_ff        <= sd_in;
      out_data_ff  <= out_data_in;
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clear_addr_ff  <= '0;
         frame_count_ff <= '0;
         dropped_ff     <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clear_addr_ff  <= clear_addr_in;
         frame_count_ff <= frame_count_in;
         dropped_ff     <= dropped_in;
         out_valid_ff   <= out_valid_in;
      end
   end

endmodule

@@ hw/rtl/pixel_pedestal_noise_accumulator.sv @@
// Per-pixel pedestal and noise accumulator.
// Requests enter through a queue-style port: a transfer happens on a rising edge with
// req_push high and req_full low. An accumulate request adds its signed sample to the
// pixel's running sum and sum of squares, and a last-of-frame flag counts one frame;
// once the frame count has saturated, accumulates are dropped. A readout request yields
// one result: mean and standard deviation in Q8, the frame count and the sticky
// saturation flag. Results leave through rsp_data while rsp_empty is low, and a
// transfer happens on an edge with rsp_pop high.
// A front stage classifies requests into a two-entry queue; the back stage executes
// them one at a time. An accumulate passes through dispatch, store read and store
// write, the read-modify-write of the store; one that touches no store entry ends at
// dispatch. A readout reads the store, forms the products and the difference, and
// passes through the shared bit-serial divider for the mean, then, when more than one
// frame is counted, again for the variance and, unless that overflows, the square root;
// an empty or out-of-range readout goes from dispatch straight to the result.
// After reset the store's 143560 entries are cleared one per cycle, during which
// req_full stays high. If the receiver stalls, the finished result waits in the
// output register, the back stage holds its next result and the queue keeps filling.
module pixel_pedestal_noise_accumulator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  ppna_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output ppna_pkg::rsp_type rsp_data
);

   ppna_pkg::fifo_head_type   head;
   ppna_pkg::back_status_type status;

   // The front stage only classifies and queues; all ordering-sensitive state lives in
   // the back stage, so frame counts seen by a readout reflect every earlier accumulate.
   ppna_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .head     (head),
      .status   (status)
   );

   ppna_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (status),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
